// ===== hw/rtl/tab_pkg.sv =====
// Shared types, constants and action codes for the triangle adjacency block.
// No dependencies; imported by tab_store, tab_match and triangle_adjacency_builder.
`default_nettype none

package tab_pkg;

    // Field widths fixed by the item format
    localparam int COORD_W = 32;
    localparam int QIDX_W  = 10;
    localparam int LINK_W  = 11;
    localparam int SHARE_W = 3;

    // Default table depth in triangles
    localparam int MAX_TRIANGLES_DEF = 1024;

    // Action codes
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    // Answer for an edge with no neighbor
    localparam logic [LINK_W-1:0] NO_LINK = {LINK_W{1'b1}};

    // Shared vertex hits needed for a neighbor
    localparam logic [SHARE_W-1:0] MIN_SHARED = 3'd2;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } vertex_t;

    // Index 0 is v0, 1 is v1, 2 is v2
    typedef vertex_t [2:0] tri_t;

    // Per-edge neighbor hits: A = v0-v1, B = v1-v2, C = v2-v0
    typedef struct packed {
        logic a;
        logic b;
        logic c;
    } edge_hit_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tab_store.sv =====
// Triangle table memory: one row of three vertices per triangle.
// One write port, one read port with registered read data. Uses tab_pkg.
`default_nettype none

module tab_store
    import tab_pkg::*;
#(
    parameter int DEPTH = MAX_TRIANGLES_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire tri_t          wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output tri_t               rd_data
);

    tri_t mem [DEPTH];
    tri_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, reads every cycle
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tab_match.sv =====
// Shared compare unit: matches a scanned triangle against the queried one.
// Gives the neighbor hit for each edge (A, B and C). Uses tab_pkg.
`default_nettype none

module tab_match
    import tab_pkg::*;
(
    input  wire tri_t self_tri,
    input  wire tri_t cand_tri,
    output edge_hit_t hit
);

    // eq[k][j]: candidate vertex k equals queried vertex j
    logic [2:0][2:0] eq;
    logic [SHARE_W-1:0] cnt_a;
    logic [SHARE_W-1:0] cnt_b;
    logic [SHARE_W-1:0] cnt_c;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                eq[k][j] = (cand_tri[k] == self_tri[j]);
            end
        end
    end

    // Count endpoint hits per edge; a degenerate edge counts one vertex twice
    always_comb
    begin
        cnt_a = '0;
        cnt_b = '0;
        cnt_c = '0;
        for (int k = 0; k < 3; k++)
        begin
            cnt_a = cnt_a + SHARE_W'(eq[k][0]) + SHARE_W'(eq[k][1]);
            cnt_b = cnt_b + SHARE_W'(eq[k][1]) + SHARE_W'(eq[k][2]);
            cnt_c = cnt_c + SHARE_W'(eq[k][2]) + SHARE_W'(eq[k][0]);
        end
    end

    assign hit.a = (cnt_a >= MIN_SHARED);
    assign hit.b = (cnt_b >= MIN_SHARED);
    assign hit.c = (cnt_c >= MIN_SHARED);

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_adjacency_builder.sv =====
// Clear and append items leave busy low, and no result follows.
// A query with a valid index holds busy while the LOAD state reads the queried
// row, then the SCAN state feeds the compare unit one stored row per cycle
// from the table's single read port. done pulses in the cycle after the last row.
// A query at or past the count pulses done in the cycle after it is accepted.
// Reset clears the count and the sequencer; table contents are not cleared.
`default_nettype none

module triangle_adjacency_builder
    import tab_pkg::*;
#(
    parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               action,
    input  wire logic [COORD_W-1:0]       a_x,
    input  wire logic [COORD_W-1:0]       a_y,
    input  wire logic [COORD_W-1:0]       a_z,
    input  wire logic [COORD_W-1:0]       b_x,
    input  wire logic [COORD_W-1:0]       b_y,
    input  wire logic [COORD_W-1:0]       b_z,
    input  wire logic [COORD_W-1:0]       c_x,
    input  wire logic [COORD_W-1:0]       c_y,
    input  wire logic [COORD_W-1:0]       c_z,
    input  wire logic [QIDX_W-1:0]        query_index,
    output logic                          done,
    output logic signed [LINK_W-1:0]      link_a,
    output logic signed [LINK_W-1:0]      link_b,
    output logic signed [LINK_W-1:0]      link_c,
    output logic                          bad_index
);

    localparam int IDX_W = $clog2(MAX_TRIANGLES);
    localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
    localparam int CMP_W = (CNT_W > QIDX_W) ? CNT_W : QIDX_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  scan_reg;
    logic [IDX_W-1:0]  self_idx_reg;
    tri_t              self_tri_reg;
    logic [LINK_W-1:0] lnk_a_reg;
    logic [LINK_W-1:0] lnk_b_reg;
    logic [LINK_W-1:0] lnk_c_reg;
    logic [LINK_W-1:0] lnk_a_next;
    logic [LINK_W-1:0] lnk_b_next;
    logic [LINK_W-1:0] lnk_c_next;
    logic [LINK_W-1:0] out_a_reg;
    logic [LINK_W-1:0] out_b_reg;
    logic [LINK_W-1:0] out_c_reg;
    logic              bad_reg;
    logic              done_reg;

    logic              accept;
    logic              q_bad;
    logic              can_append;
    logic              wr_en;
    logic              scan_last;
    logic              not_self;
    logic [IDX_W-1:0]  rd_addr;
    logic [LINK_W-1:0] scan_link;
    tri_t              wr_tri;
    tri_t              rd_tri;
    edge_hit_t         hit;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign q_bad      = (CMP_W'(query_index) >= CMP_W'(count_reg));
    assign can_append = (count_reg < CNT_W'(MAX_TRIANGLES));
    assign wr_en      = accept && (action == ACT_APPEND) && can_append;

    assign wr_tri[0] = '{x: a_x, y: a_y, z: a_z};
    assign wr_tri[1] = '{x: b_x, y: b_y, z: b_z};
    assign wr_tri[2] = '{x: c_x, y: c_y, z: c_z};

    // Read address: queried row on accept, then the scan runs one row ahead
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: rd_addr = IDX_W'(query_index);
            ST_LOAD: rd_addr = '0;
            ST_SCAN: rd_addr = scan_reg + IDX_W'(1);
            default: rd_addr = '0;
        endcase
    end

    tab_store #(
        .DEPTH (MAX_TRIANGLES),
        .AW    (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_tri),
        .rd_addr (rd_addr),
        .rd_data (rd_tri)
    );

    tab_match u_match (
        .self_tri (self_tri_reg),
        .cand_tri (rd_tri),
        .hit      (hit)
    );

    // Last-match-wins update for the row under compare
    assign scan_last = ((CNT_W'(scan_reg) + CNT_W'(1)) == count_reg);
    assign not_self  = (scan_reg != self_idx_reg);
    assign scan_link = LINK_W'(scan_reg);

    assign lnk_a_next = (hit.a && not_self) ? scan_link : lnk_a_reg;
    assign lnk_b_next = (hit.b && not_self) ? scan_link : lnk_b_reg;
    assign lnk_c_next = (hit.c && not_self) ? scan_link : lnk_c_reg;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (action == ACT_QUERY) && !q_bad)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (accept && (action == ACT_QUERY) && q_bad) ||
                         ((state_reg == ST_SCAN) && scan_last);
            if (accept && (action == ACT_CLEAR))
            begin
                count_reg <= '0;
            end
            else if (wr_en)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    // Query datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            self_idx_reg <= IDX_W'(query_index);
        end
        if (accept && (action == ACT_QUERY) && q_bad)
        begin
            out_a_reg <= NO_LINK;
            out_b_reg <= NO_LINK;
            out_c_reg <= NO_LINK;
            bad_reg   <= 1'b1;
        end
        if (state_reg == ST_LOAD)
        begin
            self_tri_reg <= rd_tri;
            scan_reg     <= '0;
            lnk_a_reg    <= NO_LINK;
            lnk_b_reg    <= NO_LINK;
            lnk_c_reg    <= NO_LINK;
        end
        if (state_reg == ST_SCAN)
        begin
            scan_reg  <= scan_reg + IDX_W'(1);
            lnk_a_reg <= lnk_a_next;
            lnk_b_reg <= lnk_b_next;
            lnk_c_reg <= lnk_c_next;
            if (scan_last)
            begin
                out_a_reg <= lnk_a_next;
                out_b_reg <= lnk_b_next;
                out_c_reg <= lnk_c_next;
                bad_reg   <= 1'b0;
            end
        end
    end

    assign done      = done_reg;
    assign link_a    = signed'(out_a_reg);
    assign link_b    = signed'(out_b_reg);
    assign link_c    = signed'(out_c_reg);
    assign bad_index = bad_reg;

    // Count never runs past the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TRIANGLES))
        else $error("stored count exceeds table depth");

    // Scan only visits stored rows
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CNT_W'(scan_reg) < count_reg))
        else $error("scan index past stored count");

    // A result comes from the end of a scan or from a bad query
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (bad_index || ($past(state_reg) == ST_SCAN)))
        else $error("result without finished scan");

    // Bad query reports no links
    a_bad_links: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_index) |->
            (out_a_reg == NO_LINK && out_b_reg == NO_LINK && out_c_reg == NO_LINK))
        else $error("bad query with a link");

    // Good query enters the load cycle
    a_query_load: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == ACT_QUERY) && !q_bad) |=> (state_reg == ST_LOAD))
        else $error("query did not start a scan");

endmodule

`default_nettype wire
